// ===== rtl/pfr_pkg.sv =====
// Shared constants, register map and controller state type for the page frame replacement block.
package pfr_pkg;

    // Default sizes
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;

    // Fixed field widths of the result word
    localparam int FI_W    = 4;
    localparam int FAULT_W = 32;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int FRAMES_REG_W = 5;
    localparam logic [FRAMES_REG_W-1:0] FRAMES_REG_RST = 5'd16;

    // Register indexes (byte address bit 2)
    localparam logic REG_ALGORITHM = 1'b0;
    localparam logic REG_FRAMES    = 1'b1;

    // Replacement policy codes
    localparam logic ALG_FIFO = 1'b0;
    localparam logic ALG_LRU  = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DONE
    } t_state;

endpackage

// ===== rtl/pfr_if.sv =====
// Request and response channel interfaces of the page frame replacement block.
interface pfr_req_if import pfr_pkg::*; #(
    parameter int PAGE_BITS = PAGE_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_id;

    modport source (output valid, output page_id, input ready);
    modport sink   (input valid, input page_id, output ready);
endinterface

interface pfr_rsp_if import pfr_pkg::*; #(
    parameter int PAGE_BITS = PAGE_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [FI_W-1:0]      frame_index;
    logic                 filled_empty;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [FAULT_W-1:0]   fault_total;

    modport source (output valid, output hit, output frame_index, output filled_empty,
                    output evicted_valid, output evicted_page, output fault_total,
                    input ready);
    modport sink   (input valid, input hit, input frame_index, input filled_empty,
                    input evicted_valid, input evicted_page, input fault_total,
                    output ready);
endinterface

// ===== rtl/page_frame_replacement_top.sv =====
// Top level of the page frame replacement block: configuration registers, cell chain and controller.
//
// Each request word carries one page number. The block searches its FRAMES frame cells for the
// page, reports a hit, fills the lowest empty frame, or replaces a victim chosen by a rotating
// FIFO pointer or by the oldest use stamp (least recently used, lowest frame on ties), and
// returns one response word with the frame, any evicted page and the saturating fault total.
// The search word walks the cell chain one frame per cycle, registered in each cell; the word at
// chain end is held in the controller, the access then commits and loads the response word into
// the output register, and the next request is taken the cycle after the access commits, so no
// request is taken while one is in flight. A response word left waiting in the output register
// lets the next search run but holds its commit, and with it the following request, until the
// waiting word is taken. Configuration: register 0 (byte address 0) selects the
// policy, 0 FIFO and 1 LRU; register 1 (byte address 4) sets the number of frames in use,
// where 0 acts as 1 and values above FRAMES act as FRAMES. Write them only while the block
// is idle.
module page_frame_replacement_top import pfr_pkg::*; #(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    pfr_req_if.sink           i_req,
    pfr_rsp_if.source         o_rsp
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int CMP_W = (CNT_W > FRAMES_REG_W) ? CNT_W : FRAMES_REG_W;

    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
        logic [IDX_W-1:0]     fifo_idx;
        logic                 hit;
        logic [IDX_W-1:0]     hit_idx;
        logic                 empty;
        logic [IDX_W-1:0]     empty_idx;
        logic                 old_found;
        logic [IDX_W-1:0]     old_idx;
        logic [TIME_BITS-1:0] old_stamp;
        logic [PAGE_BITS-1:0] old_page;
        logic [PAGE_BITS-1:0] fifo_page;
    } t_sweep;

    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     idx;
        logic                 load;
        logic [PAGE_BITS-1:0] page;
        logic                 wr_stamp;
        logic [TIME_BITS-1:0] stamp;
    } t_upd;

    logic                    r_algorithm;
    logic [FRAMES_REG_W-1:0] r_frames_in_use;
    logic                    w_wr;
    logic [CMP_W-1:0]        w_frames_ext;
    logic [CNT_W-1:0]        w_frames;
    t_sweep                  w_word [FRAMES+1];
    t_upd                    w_upd;

    // Write configuration registers on the access phase
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_algorithm     <= ALG_FIFO;
            r_frames_in_use <= FRAMES_REG_RST;
        end else if (w_wr) begin
            case (paddr[2])
                REG_ALGORITHM: r_algorithm     <= pwdata[0];
                REG_FRAMES:    r_frames_in_use <= pwdata[FRAMES_REG_W-1:0];
                default:       r_algorithm     <= r_algorithm;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (paddr[2])
            REG_ALGORITHM: prdata = DATA_W'(r_algorithm);
            REG_FRAMES:    prdata = DATA_W'(r_frames_in_use);
            default:       prdata = '0;
        endcase
    end

    // Clamp the frame count to 1..FRAMES
    assign w_frames_ext = CMP_W'(r_frames_in_use);

    always_comb begin
        if (w_frames_ext == '0) begin
            w_frames = CNT_W'(1);
        end else if (w_frames_ext > CMP_W'(FRAMES)) begin
            w_frames = CNT_W'(FRAMES);
        end else begin
            w_frames = CNT_W'(w_frames_ext);
        end
    end

    pfr_ctrl #(
        .PAGE_BITS (PAGE_BITS),
        .TIME_BITS (TIME_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W),
        .t_sweep   (t_sweep),
        .t_upd     (t_upd)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_algorithm (r_algorithm),
        .i_frames    (w_frames),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_word      (w_word[0]),
        .i_word      (w_word[FRAMES]),
        .o_upd       (w_upd)
    );

    // Chain of frame cells
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        pfr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .TIME_BITS (TIME_BITS),
            .IDX_W     (IDX_W),
            .CNT_W     (CNT_W),
            .POS       (g),
            .t_sweep   (t_sweep),
            .t_upd     (t_upd)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_frames (w_frames),
            .i_word   (w_word[g]),
            .i_upd    (w_upd),
            .o_word   (w_word[g+1])
        );
    end

endmodule

// ===== rtl/pfr_cell.sv =====
// One frame cell: holds a resident page, valid bit and use stamp, and updates the passing search word.
module pfr_cell import pfr_pkg::*; #(
    parameter int  PAGE_BITS = PAGE_BITS_DEF,
    parameter int  TIME_BITS = TIME_BITS_DEF,
    parameter int  IDX_W     = 4,
    parameter int  CNT_W     = 5,
    parameter int  POS       = 0,
    parameter type t_sweep   = logic,
    parameter type t_upd     = logic
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_frames,
    input  t_sweep           i_word,
    input  t_upd             i_upd,
    output t_sweep           o_word
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(POS);
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(POS);

    logic                 r_valid;
    logic [PAGE_BITS-1:0] r_page;
    logic [TIME_BITS-1:0] r_stamp;
    t_sweep               r_word;
    t_sweep               n_word;
    logic                 w_active;
    logic                 w_sel;

    assign w_active = (MY_POS < i_frames);
    assign w_sel    = i_upd.en && (i_upd.idx == MY_IDX);

    // Fold this frame into the passing search word
    always_comb begin
        n_word = i_word;
        if (i_word.valid && w_active) begin
            if (r_valid && (r_page == i_word.page) && !i_word.hit) begin
                n_word.hit     = 1'b1;
                n_word.hit_idx = MY_IDX;
            end
            if (!r_valid && !i_word.empty) begin
                n_word.empty     = 1'b1;
                n_word.empty_idx = MY_IDX;
            end
            if (!i_word.old_found || (r_stamp < i_word.old_stamp)) begin
                n_word.old_found = 1'b1;
                n_word.old_idx   = MY_IDX;
                n_word.old_stamp = r_stamp;
                n_word.old_page  = r_page;
            end
            if (i_word.fifo_idx == MY_IDX) begin
                n_word.fifo_page = r_page;
            end
        end
    end

    // Advance the search word to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else begin
            r_word <= n_word;
        end
    end

    // Apply commit updates addressed to this frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_stamp <= '0;
        end else if (w_sel) begin
            if (i_upd.load) begin
                r_valid <= 1'b1;
            end
            if (i_upd.wr_stamp) begin
                r_stamp <= i_upd.stamp;
            end
        end
    end

    // Page store, only read behind the valid bit
    always_ff @(posedge i_clk) begin
        if (w_sel && i_upd.load) begin
            r_page <= i_upd.page;
        end
    end

    assign o_word = r_word;

endmodule

// ===== rtl/pfr_ctrl.sv =====
// Access controller: injects search words, picks the action at chain end, commits and drives results.
module pfr_ctrl import pfr_pkg::*; #(
    parameter int  PAGE_BITS = PAGE_BITS_DEF,
    parameter int  TIME_BITS = TIME_BITS_DEF,
    parameter int  IDX_W     = 4,
    parameter int  CNT_W     = 5,
    parameter type t_sweep   = logic,
    parameter type t_upd     = logic
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_algorithm,
    input  logic [CNT_W-1:0] i_frames,
    pfr_req_if.sink          i_req,
    pfr_rsp_if.source        o_rsp,
    output t_sweep           o_word,
    input  t_sweep           i_word,
    output t_upd             o_upd
);

    t_state               r_state;
    t_state               n_state;
    logic [TIME_BITS-1:0] r_clock;
    logic [FAULT_W-1:0]   r_faults;
    logic [FAULT_W-1:0]   n_faults;
    logic [IDX_W-1:0]     r_fifo_next;
    logic [IDX_W-1:0]     n_fifo_next;
    t_sweep               r_done;

    logic                 r_out_valid;
    logic                 r_hit;
    logic [FI_W-1:0]      r_frame_index;
    logic                 r_filled_empty;
    logic                 r_evicted_valid;
    logic [PAGE_BITS-1:0] r_evicted_page;
    logic [FAULT_W-1:0]   r_fault_total;

    logic                 w_accept;
    logic                 w_commit;
    logic [IDX_W-1:0]     w_fifo_start;
    logic [IDX_W-1:0]     w_frame;
    logic                 w_filled;
    logic                 w_evict;
    logic [PAGE_BITS-1:0] w_evicted_page;
    logic [CNT_W-1:0]     w_fifo_inc;
    t_upd                 w_upd;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept)      n_state = S_SWEEP;
            S_SWEEP: if (i_word.valid)  n_state = S_DONE;
            S_DONE:  if (w_commit)      n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs; hold off requests while in reset
    always_comb begin
        i_req.ready = 1'b0;
        w_commit    = 1'b0;
        case (r_state)
            S_IDLE:  i_req.ready = i_rst_n;
            S_SWEEP: i_req.ready = 1'b0;
            S_DONE:  w_commit    = !r_out_valid || o_rsp.ready;
            default: i_req.ready = 1'b0;
        endcase
    end

    assign w_accept = i_req.valid && i_req.ready;

    // Wrap a stale FIFO pointer before it is used
    assign w_fifo_start = (CNT_W'(r_fifo_next) >= i_frames) ? '0 : r_fifo_next;

    // Build the search word for cell zero
    always_comb begin
        o_word          = '0;
        o_word.valid    = w_accept;
        o_word.page     = i_req.page_id;
        o_word.fifo_idx = w_fifo_start;
    end

    // Choose hit, empty fill or replacement from the finished search word
    always_comb begin
        w_frame        = '0;
        w_filled       = 1'b0;
        w_evict        = 1'b0;
        w_evicted_page = '0;
        n_faults       = r_faults;
        n_fifo_next    = r_fifo_next;
        w_fifo_inc     = CNT_W'(r_done.fifo_idx) + CNT_W'(1);
        w_upd          = '0;
        w_upd.idx      = '0;
        w_upd.page     = r_done.page;
        w_upd.stamp    = r_clock;
        if (r_done.hit) begin
            w_frame        = r_done.hit_idx;
            w_upd.idx      = r_done.hit_idx;
            w_upd.wr_stamp = (i_algorithm == ALG_LRU);
        end else begin
            if (r_faults != FAULT_MAX) begin
                n_faults = r_faults + FAULT_W'(1);
            end
            w_upd.load = 1'b1;
            if (r_done.empty) begin
                w_frame        = r_done.empty_idx;
                w_filled       = 1'b1;
                w_upd.idx      = r_done.empty_idx;
                w_upd.wr_stamp = (i_algorithm == ALG_LRU);
            end else begin
                w_evict        = 1'b1;
                w_upd.wr_stamp = 1'b1;
                if (i_algorithm == ALG_FIFO) begin
                    w_frame        = r_done.fifo_idx;
                    w_evicted_page = r_done.fifo_page;
                    n_fifo_next    = (w_fifo_inc >= i_frames) ? '0 : IDX_W'(w_fifo_inc);
                end else begin
                    w_frame        = r_done.old_idx;
                    w_evicted_page = r_done.old_page;
                end
                w_upd.idx = w_frame;
            end
        end
        w_upd.en = w_commit;
    end

    assign o_upd = w_upd;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clock     <= '0;
            r_faults    <= '0;
            r_fifo_next <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_clock <= r_clock + TIME_BITS'(1);
            end
            if (w_commit) begin
                r_faults    <= n_faults;
                r_fifo_next <= n_fifo_next;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the search word at chain end and load the result word
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SWEEP) && i_word.valid) begin
            r_done <= i_word;
        end
        if (w_commit) begin
            r_hit           <= r_done.hit;
            r_frame_index   <= FI_W'(w_frame);
            r_filled_empty  <= w_filled;
            r_evicted_valid <= w_evict;
            r_evicted_page  <= w_evicted_page;
            r_fault_total   <= n_faults;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_hit;
    assign o_rsp.frame_index   = r_frame_index;
    assign o_rsp.filled_empty  = r_filled_empty;
    assign o_rsp.evicted_valid = r_evicted_valid;
    assign o_rsp.evicted_page  = r_evicted_page;
    assign o_rsp.fault_total   = r_fault_total;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for page_frame_replacement_top: table-driven and random accesses.
module tb_top;
    import pfr_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 60;
    localparam int SEGMENTS     = 10;
    localparam int SEG_WORDS    = 100;
    localparam int POOL_SIZE    = 20;
    localparam int PLAN_ROWS    = 28;

    // One response word, in port order
    typedef struct packed {
        logic                     hit;
        logic [FI_W-1:0]          frame_index;
        logic                     filled_empty;
        logic                     evicted_valid;
        logic [PAGE_BITS_DEF-1:0] evicted_page;
        logic [FAULT_W-1:0]       fault_total;
    } access_result_t;

    typedef enum logic [1:0] {
        ROW_ACCESS,
        ROW_SET_ALG,
        ROW_SET_FRAMES
    } row_kind_e;

    typedef struct packed {
        row_kind_e      kind;
        logic [15:0]    arg;
        logic           pinned;
        access_result_t want;
    } stim_row_t;

    typedef struct {
        int             seq;
        access_result_t want;
    } pinned_t;

    localparam access_result_t NO_RESULT = '0;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pfr_req_if req_if ();
    pfr_rsp_if rsp_if ();

    page_frame_replacement_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Frame table mirror and settings
    logic [PAGE_BITS_DEF-1:0] page_tbl [FRAMES_DEF];
    logic                     used     [FRAMES_DEF];
    logic [TIME_BITS_DEF-1:0] stamp    [FRAMES_DEF];
    logic [TIME_BITS_DEF-1:0] tick     = '0;
    logic [FAULT_W-1:0]       faults   = '0;
    int                       fifo_cursor = 0;
    logic                     mode     = ALG_FIFO;
    logic [FRAMES_REG_W-1:0]  frame_cnt = FRAMES_REG_RST;

    access_result_t pending_q [$];
    pinned_t        pinned_q  [$];
    int             sent_count = 0;
    int             rsp_seen   = 0;
    int             errors     = 0;
    int             snd_idle_pct = 37;
    int             rsp_idle_pct = 61;
    int             hold_req  = 0;
    int             hold_ack  = 0;
    int             hold_left = 0;

    // Directed sequence: fills, hits, FIFO wrap, pointer reset after shrinking the frame
    // count, count of zero and above the maximum, stale frames beyond the count, then LRU
    // with tied stamps left by FIFO-mode fills and a refreshed hit.
    stim_row_t plan [PLAN_ROWS] = '{
        {ROW_ACCESS,     16'h0000, 1'b1, {1'b0, 4'd0, 1'b1, 1'b0, 16'h0000, 32'd1}},
        {ROW_ACCESS,     16'hFFFF, 1'b1, {1'b0, 4'd1, 1'b1, 1'b0, 16'h0000, 32'd2}},
        {ROW_ACCESS,     16'h0000, 1'b1, {1'b1, 4'd0, 1'b0, 1'b0, 16'h0000, 32'd2}},
        {ROW_SET_FRAMES, 16'd2,    1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h1234, 1'b1, {1'b0, 4'd0, 1'b0, 1'b1, 16'h0000, 32'd3}},
        {ROW_ACCESS,     16'hFFFF, 1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h8001, 1'b0, NO_RESULT},
        {ROW_SET_FRAMES, 16'd3,    1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h5555, 1'b0, NO_RESULT},
        {ROW_ACCESS,     16'hAAAA, 1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h0F0F, 1'b0, NO_RESULT},
        {ROW_SET_FRAMES, 16'd2,    1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h7FFF, 1'b0, NO_RESULT},
        {ROW_SET_FRAMES, 16'd0,    1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h0F0F, 1'b0, NO_RESULT},
        {ROW_SET_FRAMES, 16'd31,   1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h0F0F, 1'b0, NO_RESULT},
        {ROW_SET_FRAMES, 16'd6,    1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h0001, 1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h0002, 1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h0003, 1'b0, NO_RESULT},
        {ROW_SET_ALG,    16'd1,    1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h0004, 1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h0003, 1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h0005, 1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h0006, 1'b0, NO_RESULT},
        {ROW_SET_FRAMES, 16'd16,   1'b0, NO_RESULT},
        {ROW_ACCESS,     16'h0007, 1'b0, NO_RESULT}
    };

    always #2 i_clk = ~i_clk;

    function automatic void note_error(string msg);
        errors++;
        if (errors <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void compare_result(string tag, access_result_t want, access_result_t got);
        if (got !== want) begin
            note_error($sformatf({"%s mismatch on word %0d: want hit=%0b frame=%0d fill=%0b ",
                "evict=%0b page=%h faults=%0d, got hit=%0b frame=%0d fill=%0b evict=%0b ",
                "page=%h faults=%0d"}, tag, rsp_seen,
                want.hit, want.frame_index, want.filled_empty, want.evicted_valid,
                want.evicted_page, want.fault_total,
                got.hit, got.frame_index, got.filled_empty, got.evicted_valid,
                got.evicted_page, got.fault_total));
        end
    endfunction

    // Apply one access to the mirrored frame table and return the word it should produce
    function automatic access_result_t predict_access(logic [PAGE_BITS_DEF-1:0] page);
        access_result_t r;
        int n;
        int victim;
        logic [TIME_BITS_DEF-1:0] oldest;
        n = (frame_cnt == 0) ? 1 : ((frame_cnt > FRAMES_DEF) ? FRAMES_DEF : int'(frame_cnt));
        tick = tick + 1'b1;
        r = '0;
        for (int i = 0; i < n; i++) begin
            if (used[i] && page_tbl[i] == page) begin
                if (mode == ALG_LRU) begin
                    stamp[i] = tick;
                end
                r.hit = 1'b1;
                r.frame_index = FI_W'(i);
                r.fault_total = faults;
                return r;
            end
        end
        if (faults != FAULT_MAX) begin
            faults = faults + 1'b1;
        end
        r.fault_total = faults;
        for (int i = 0; i < n; i++) begin
            if (!used[i]) begin
                used[i] = 1'b1;
                page_tbl[i] = page;
                if (mode == ALG_LRU) begin
                    stamp[i] = tick;
                end
                r.frame_index = FI_W'(i);
                r.filled_empty = 1'b1;
                return r;
            end
        end
        if (mode == ALG_FIFO) begin
            if (fifo_cursor >= n) begin
                fifo_cursor = 0;
            end
            victim = fifo_cursor;
            fifo_cursor = (fifo_cursor + 1 >= n) ? 0 : fifo_cursor + 1;
        end else begin
            // oldest stamp wins, lowest frame on ties
            victim = 0;
            oldest = stamp[0];
            for (int i = 1; i < n; i++) begin
                if (stamp[i] < oldest) begin
                    oldest = stamp[i];
                    victim = i;
                end
            end
        end
        r.frame_index = FI_W'(victim);
        r.evicted_valid = 1'b1;
        r.evicted_page = page_tbl[victim];
        page_tbl[victim] = page;
        used[victim] = 1'b1;
        stamp[victim] = tick;
        return r;
    endfunction

    // Predict on every accepted request, check every accepted response
    always @(posedge i_clk) begin
        access_result_t got;
        pinned_t pin;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                pending_q.push_back(predict_access(req_if.page_id));
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got = {rsp_if.hit, rsp_if.frame_index, rsp_if.filled_empty,
                       rsp_if.evicted_valid, rsp_if.evicted_page, rsp_if.fault_total};
                if (pending_q.size() == 0) begin
                    note_error($sformatf("response word %0d arrived with nothing pending",
                        rsp_seen));
                end else begin
                    compare_result("predicted", pending_q.pop_front(), got);
                end
                if (pinned_q.size() != 0 && pinned_q[0].seq == rsp_seen) begin
                    pin = pinned_q.pop_front();
                    compare_result("table", pin.want, got);
                end
                rsp_seen++;
            end
        end
    end

    // Response side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
        end
    end

    task automatic write_reg(logic idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Read a register back and compare with the mirrored setting
    task automatic check_reg(logic idx);
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        want = (idx == REG_ALGORITHM) ? DATA_W'(mode) : DATA_W'(frame_cnt);
        if (data !== want) begin
            note_error($sformatf("register %0d reads %h, want %h", idx, data, want));
        end
    endtask

    task automatic set_reg(logic idx, logic [DATA_W-1:0] value);
        write_reg(idx, value);
        if (idx == REG_ALGORITHM) begin
            mode = value[0];
        end else begin
            frame_cnt = value[FRAMES_REG_W-1:0];
        end
        check_reg(idx);
    endtask

    // Offer one word after a random gap and hold it until taken
    task automatic send_page(logic [PAGE_BITS_DEF-1:0] page);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.page_id <= page;
        do @(posedge i_clk); while (!req_if.ready);
        sent_count++;
    endtask

    // Stop offering and wait until every sent word has its response
    task automatic drain();
        req_if.valid <= 1'b0;
        while (rsp_seen != sent_count) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int seg_frames [SEGMENTS];
        logic [PAGE_BITS_DEF-1:0] pool [POOL_SIZE];
        stim_row_t r;
        int nfr;
        int span;
        logic [PAGE_BITS_DEF-1:0] page;

        seg_frames = '{16, 1, 5, 31, 0, 8, 16, 3, 12, 16};
        req_if.valid = 1'b0;
        req_if.page_id = '0;
        for (int i = 0; i < FRAMES_DEF; i++) begin
            page_tbl[i] = '0;
            used[i]     = 1'b0;
            stamp[i]    = '0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_reg(REG_ALGORITHM);
        check_reg(REG_FRAMES);

        // Walk the directed table
        foreach (plan[k]) begin
            r = plan[k];
            case (r.kind)
                ROW_SET_ALG: begin
                    drain();
                    set_reg(REG_ALGORITHM, DATA_W'(r.arg));
                end
                ROW_SET_FRAMES: begin
                    drain();
                    set_reg(REG_FRAMES, DATA_W'(r.arg));
                end
                default: begin
                    if (r.pinned) begin
                        pinned_q.push_back('{sent_count, r.want});
                    end
                    send_page(r.arg);
                end
            endcase
        end

        // Random segments, each with its own setting and working set of pages
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            set_reg(REG_ALGORITHM, DATA_W'((seg % 2 == 0) ? ALG_LRU : ALG_FIFO));
            set_reg(REG_FRAMES, DATA_W'(seg_frames[seg]));
            if (seg < 4) begin
                snd_idle_pct = 37;
                rsp_idle_pct = 61;
            end else if (seg < 7) begin
                snd_idle_pct = 61;
                rsp_idle_pct = 37;
            end else begin
                snd_idle_pct = 0;
                rsp_idle_pct = 0;
            end
            if (seg == 7) begin
                hold_req++;
            end
            nfr  = (seg_frames[seg] == 0) ? 1 :
                   ((seg_frames[seg] > FRAMES_DEF) ? FRAMES_DEF : seg_frames[seg]);
            span = (nfr + 3 > POOL_SIZE) ? POOL_SIZE : nfr + 3;
            foreach (pool[i]) begin
                pool[i] = PAGE_BITS_DEF'($urandom_range(0, 65535));
            end
            for (int w = 0; w < SEG_WORDS; w++) begin
                if (seg == 5 && w == SEG_WORDS / 2) begin
                    drain();
                end
                if ($urandom_range(0, 99) < 80) begin
                    page = pool[$urandom_range(0, span - 1)];
                end else begin
                    page = PAGE_BITS_DEF'($urandom_range(0, 65535));
                end
                send_page(page);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_CYCLES * 4);
        $display("TB_ERROR");
        $finish;
    end

endmodule
